/* rtl/core/ccff_pkg.sv */
package ccff_pkg;

    localparam int GAIN_W  = 32;
    localparam int RAD_W   = 32;
    localparam int MAXF_W  = 31;
    localparam int TICK_W  = 16;
    localparam int FORCE_W = 32;
    localparam int QUOT_W  = 32;

    localparam logic [1:0] CFG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_RADIUS  = 2'd1;
    localparam logic [1:0] CFG_MAXF    = 2'd2;
    localparam logic [1:0] CFG_STARTUP = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RST    = 32'd2621440;
    localparam logic [RAD_W-1:0]  RADIUS_RST  = 32'd327680;
    localparam logic [MAXF_W-1:0] MAXF_RST    = 31'd216269;
    localparam logic [TICK_W-1:0] STARTUP_RST = 16'd2000;

    typedef logic [FORCE_W-1:0] force_t;

endpackage

/* rtl/core/clamped_charge_force_field_top.sv */
// channel  | valid / ready           | payload
// s_ (in)  | s_valid / s_ready       | s_pos_a_x..z, s_pos_b_x..z
// m_ (out) | m_valid / m_ready       | m_force_x..z, m_force_enabled, m_in_core
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
// Each item runs SQ, LAW, NUM/DIV per axis and OUT; no new item is taken until idle:
// one shared 32x32 multiplier forms the squares and products, then one restoring divider
// produces the three 32-bit quotients one bit per cycle.
// Synchronous active-low reset clears control state and loads register defaults.
// The next item is taken once the result sits in the output register, so the
// result may wait on m_ready while the next item starts work.
module clamped_charge_force_field_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [31:0]               s_pos_a_x,
    input  logic [31:0]               s_pos_a_y,
    input  logic [31:0]               s_pos_a_z,
    input  logic [31:0]               s_pos_b_x,
    input  logic [31:0]               s_pos_b_y,
    input  logic [31:0]               s_pos_b_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ccff_pkg::force_t          m_force_x,
    output ccff_pkg::force_t          m_force_y,
    output ccff_pkg::force_t          m_force_z,
    output logic                      m_force_enabled,
    output logic                      m_in_core,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data
);
    import ccff_pkg::*;

    localparam int CW   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam bit CSGN = (COORD_WIDTH <= 32);
    localparam int DW   = CW + 1;
    localparam int MW   = 2 * DW;
    localparam int SW   = MW + 2;
    localparam int NW   = GAIN_W + DW + 16;
    localparam int RW   = (SW > 2*RAD_W+2) ? SW : 2*RAD_W+2;
    localparam int PW   = 2 * 32 + 2;
    localparam int WW   = NW + 2;
    localparam int TW   = RW + QUOT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_LAW  = 3'd2;
    localparam logic [2:0] ST_NUM  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        axis_reg, axis_next;
    logic [5:0]        bit_reg, bit_next;
    logic [GAIN_W-1:0] gain_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [MAXF_W-1:0] maxf_reg;
    logic [TICK_W-1:0] startup_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [DW-1:0]     mag_reg [3];
    logic [2:0]        neg_reg;
    logic [RW-1:0]     sum_reg, den_reg;
    logic              core_reg, en_reg;
    logic [WW-1:0]     rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              ovf_reg;
    force_t            f_reg [3];
    logic              m_valid_reg;
    logic              m_en_reg, m_core_reg;
    force_t            m_f_reg [3];

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [DW-1:0]     dd [3];
    logic              dneg [3];
    logic [RW-1:0]     core_lim;
    logic [TW:0]       trial;
    logic [QUOT_W-1:0] quot_fin;
    logic [QUOT_W-1:0] qsat;
    force_t            fval;
    logic              tick_en;
    logic [TICK_W-1:0] tick_inc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_force_x = m_f_reg[0];
    assign m_force_y = m_f_reg[1];
    assign m_force_z = m_f_reg[2];
    assign m_force_enabled = m_en_reg;
    assign m_in_core = m_core_reg;

    always_comb begin
        logic signed [DW-1:0] a, b, d;
        logic [31:0] pa [3];
        logic [31:0] pb [3];
        pa[0] = s_pos_a_x; pa[1] = s_pos_a_y; pa[2] = s_pos_a_z;
        pb[0] = s_pos_b_x; pb[1] = s_pos_b_y; pb[2] = s_pos_b_z;
        for (int i = 0; i < 3; i++) begin
            a = CSGN ? DW'($signed(pa[i][CW-1:0])) : DW'({1'b0, pa[i][CW-1:0]});
            b = CSGN ? DW'($signed(pb[i][CW-1:0])) : DW'({1'b0, pb[i][CW-1:0]});
            d = b - a;
            dneg[i] = d[DW-1];
            dd[i] = d[DW-1] ? DW'(-d) : DW'(d);
        end
    end

    // shared multiplier: magnitudes fit 33 bits only at width 32, split handled by
    // squaring the 32-bit low part plus correction for the top bit
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_SQ:   begin
                mul_a = 32'(mag_reg[axis_reg]);
                mul_b = 32'(mag_reg[axis_reg]);
            end
            ST_LAW:  begin
                mul_a = radius_reg;
                mul_b = radius_reg;
            end
            ST_NUM:  begin
                mul_a = gain_reg;
                mul_b = 32'(mag_reg[axis_reg]);
            end
            default: begin
                mul_a = 32'd0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    logic [PW-1:0] sq_full, num_full;
    always_comb begin
        logic top;
        logic [PW-1:0] lo32;
        top  = (DW > 32) ? mag_reg[axis_reg][DW-1] : 1'b0;
        lo32 = PW'(32'(mag_reg[axis_reg]));
        sq_full  = PW'(mul_p) + (top ? ((lo32 << 33) + (PW'(1) << 64)) : PW'(0));
        num_full = PW'(mul_p) + (top ? (PW'(gain_reg) << 32) : PW'(0));
    end

    assign core_lim = RW'({PW'(mul_p), 2'b00});
    assign trial    = {1'b0, TW'(rem_reg)} - {1'b0, TW'(den_reg) << bit_reg[4:0]};
    assign quot_fin = {quot_reg[QUOT_W-1:1], ~trial[TW]};
    assign qsat     = ovf_reg ? {QUOT_W{1'b1}} : quot_fin;
    assign fval     = (qsat > QUOT_W'(maxf_reg)) ? force_t'(maxf_reg) : force_t'(qsat);
    assign tick_inc = (tick_reg == {TICK_W{1'b1}}) ? tick_reg : tick_reg + 1'b1;
    assign tick_en  = tick_inc > startup_reg;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQ;
                    axis_next  = 2'd0;
                end
            end
            ST_SQ: begin
                if (axis_reg == 2'd2) begin
                    state_next = ST_LAW;
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_LAW: begin
                state_next = ST_NUM;
                axis_next  = 2'd0;
            end
            ST_NUM: begin
                state_next = ST_DIV;
                bit_next   = 6'd32;
            end
            ST_DIV: begin
                if (bit_reg == 6'd0) begin
                    if (axis_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_NUM;
                        axis_next  = axis_reg + 1'b1;
                    end
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 2'd0;
            bit_reg     <= 6'd0;
            gain_reg    <= GAIN_RST;
            radius_reg  <= RADIUS_RST;
            maxf_reg    <= MAXF_RST;
            startup_reg <= STARTUP_RST;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            bit_reg   <= bit_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GAIN:    gain_reg    <= cfg_data;
                    CFG_RADIUS:  radius_reg  <= cfg_data;
                    CFG_MAXF:    maxf_reg    <= cfg_data[MAXF_W-1:0];
                    CFG_STARTUP: startup_reg <= cfg_data[TICK_W-1:0];
                    default:     gain_reg    <= gain_reg;
                endcase
            end
            if (state_reg == ST_LAW) begin
                tick_reg <= tick_en ? startup_reg + 1'b1 : tick_inc;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sum_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= dd[i];
                    neg_reg[i] <= dneg[i];
                end
            end
            ST_SQ: begin
                sum_reg <= sum_reg + RW'(sq_full);
            end
            ST_LAW: begin
                core_reg <= sum_reg < core_lim;
                den_reg  <= (sum_reg < core_lim) ? core_lim : sum_reg;
                en_reg   <= tick_en;
            end
            ST_NUM: begin
                rem_reg  <= WW'(num_full) << 16;
                quot_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            ST_DIV: begin
                if (bit_reg == 6'd32) begin
                    ovf_reg <= (den_reg == '0) || (TW'(rem_reg) >= (TW'(den_reg) << 32));
                end else if (!trial[TW]) begin
                    rem_reg <= trial[WW-1:0];
                    quot_reg[bit_reg[4:0]] <= 1'b1;
                end
                if (bit_reg == 6'd0) begin
                    if (!en_reg || den_reg == '0 || fval == '0) begin
                        f_reg[axis_reg] <= '0;
                    end else begin
                        f_reg[axis_reg] <= neg_reg[axis_reg] ? force_t'(-fval) : fval;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_en_reg   <= en_reg;
                    m_core_reg <= core_reg;
                    for (int i = 0; i < 3; i++) begin
                        m_f_reg[i] <= f_reg[i];
                    end
                end
            end
            default: begin
                sum_reg <= sum_reg;
            end
        endcase
    end

endmodule
